// ----- hw/rtl/sle_pkg.sv -----
// Shared types and constants for the serial line editor.
// No dependencies; imported by every module of the block.
package sle_pkg;

  // Result kinds seen on the out_kind port
  localparam logic [1:0] KIND_ECHO = 2'd0;
  localparam logic [1:0] KIND_LINE = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  // Control characters
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Command queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    OP_STORE,
    OP_ERASE,
    OP_EOL
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } cmd_t;

endpackage

// ----- hw/rtl/sle_front.sv -----
// Front end: accepts received bytes, classifies them and queues commands.
// Depends on sle_pkg; keeps its own copy of the line fill count.
module sle_front import sle_pkg::*; #(
  parameter int LINE_CAPACITY = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       q_full,
  output logic       q_push,
  output cmd_t       q_cmd
);

  localparam int CNT_W = $clog2(LINE_CAPACITY);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             is_eol, is_erase, room, nonempty, accept;

  // Classification of the incoming byte
  always_comb begin
    is_eol   = (in_rx_byte == CH_LF) || (in_rx_byte == CH_CR);
    is_erase = (in_rx_byte == CH_BS) || (in_rx_byte == CH_DEL);
    room     = (cnt_r != CNT_W'(LINE_CAPACITY - 1));
    nonempty = (cnt_r != '0);
    in_ready = !q_full;
    accept   = in_valid && in_ready;
    q_cmd.data = in_rx_byte;
    q_cmd.op   = OP_STORE;
    q_push     = 1'b0;
    cnt_nxt    = cnt_r;
    if (is_eol) begin
      q_cmd.op = OP_EOL;
      q_push   = accept;
      if (accept) cnt_nxt = '0;
    end else if (is_erase) begin
      q_cmd.op = OP_ERASE;
      q_push   = accept && nonempty;
      if (accept && nonempty) cnt_nxt = cnt_r - CNT_W'(1);
    end else begin
      // full line: byte dropped, nothing queued
      q_push = accept && room;
      if (accept && room) cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- hw/rtl/sle_cmd_fifo.sv -----
// Short command queue between the front and back ends.
// Depends on sle_pkg for cmd_t and the queue depth.
module sle_cmd_fifo import sle_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t din,
  input  logic pop,
  output cmd_t dout,
  output logic full,
  output logic empty
);

  cmd_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   cnt_r;
  logic              do_push, do_pop;

  always_comb begin
    full    = (cnt_r == (QPTR_W+1)'(QDEPTH));
    empty   = (cnt_r == '0);
    do_push = push && !full;
    do_pop  = pop && !empty;
    dout    = slot_r[rd_ptr_r];
  end

  // Storage: no reset needed
  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= din;
  end

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      if (do_push && !do_pop) cnt_r <= cnt_r + (QPTR_W+1)'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - (QPTR_W+1)'(1);
    end
  end

endmodule

// ----- hw/rtl/sle_back.sv -----
// Back end: executes queued commands, owns the line store, drives results.
// Depends on sle_pkg; output register decouples it from the sink.
module sle_back import sle_pkg::*; #(
  parameter int LINE_CAPACITY = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  cmd_t       q_cmd,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_data_byte,
  output logic       out_last
);

  localparam int CNT_W = $clog2(LINE_CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE, S_E1, S_E2, S_E3, S_LF, S_CR, S_LINE, S_END
  } state_t;

  state_t           state_r;
  op_t              op_r;
  logic [7:0]       byte_r;
  logic [CNT_W-1:0] cnt_r, idx_r, idx_nxt;
  logic [7:0]       line_mem [LINE_CAPACITY];
  logic [7:0]       rd_r;
  logic             out_valid_r, out_last_r;
  logic [1:0]       out_kind_r;
  logic [7:0]       out_data_r;
  logic             slot_free;

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_data_byte = out_data_r;
  assign out_last      = out_last_r;

  // Pop and read-address steering
  always_comb begin
    slot_free = !out_valid_r || out_ready;
    q_pop     = (state_r == S_IDLE) && !q_empty;
    idx_nxt   = idx_r;
    if (q_pop && q_cmd.op == OP_EOL) idx_nxt = '0;
    else if (state_r == S_LINE && slot_free) idx_nxt = idx_r + CNT_W'(1);
  end

  // Line store: write on store commands, registered read one step ahead
  always_ff @(posedge clk) begin
    if (q_pop && q_cmd.op == OP_STORE) line_mem[cnt_r] <= q_cmd.data;
    rd_r <= line_mem[idx_nxt];
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      idx_r       <= '0;
    end else begin
      idx_r <= idx_nxt;
      if (slot_free) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_pop) begin
            op_r   <= q_cmd.op;
            byte_r <= q_cmd.data;
            case (q_cmd.op)
              OP_STORE: begin
                cnt_r   <= cnt_r + CNT_W'(1);
                state_r <= S_E1;
              end
              OP_ERASE: begin
                cnt_r   <= cnt_r - CNT_W'(1);
                state_r <= S_E1;
              end
              OP_EOL:  state_r <= S_LF;
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_E1: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= KIND_ECHO;
            out_data_r  <= byte_r;
            out_last_r  <= (op_r == OP_STORE);
            state_r     <= (op_r == OP_STORE) ? S_IDLE : S_E2;
          end
        end
        S_E2: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= KIND_ECHO;
            out_data_r  <= CH_SPACE;
            out_last_r  <= 1'b0;
            state_r     <= S_E3;
          end
        end
        S_E3: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= KIND_ECHO;
            out_data_r  <= byte_r;
            out_last_r  <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        S_LF: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= KIND_ECHO;
            out_data_r  <= CH_LF;
            out_last_r  <= 1'b0;
            state_r     <= S_CR;
          end
        end
        S_CR: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= KIND_ECHO;
            out_data_r  <= CH_CR;
            out_last_r  <= 1'b0;
            state_r     <= (cnt_r == '0) ? S_END : S_LINE;
          end
        end
        S_LINE: begin
          // rd_r already holds line_mem[idx_r]
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= KIND_LINE;
            out_data_r  <= rd_r;
            out_last_r  <= 1'b0;
            if (idx_r == cnt_r - CNT_W'(1)) state_r <= S_END;
          end
        end
        S_END: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= KIND_END;
            out_data_r  <= '0;
            out_last_r  <= 1'b1;
            cnt_r       <= '0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/serial_line_editor_top.sv -----
// Serial line editor: front classifier, 4-entry command queue, back executor.
// Path: an accepted command is written to the queue, popped by the back end, then loaded into the output register.
// The back-end sequencer emits one result per cycle unless the sink stalls it, and pops a new command
// only once the results of the last one are all loaded; dropped bytes are never queued.
// Reset: synchronous active-low rst_n clears counts, queue and sequencer; line store is not cleared.
module serial_line_editor_top import sle_pkg::*; #(
  parameter int LINE_CAPACITY = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_data_byte,
  output logic       out_last
);

  logic q_push, q_pop, q_full, q_empty;
  cmd_t q_din, q_dout;

  sle_front #(.LINE_CAPACITY(LINE_CAPACITY)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (q_din)
  );

  sle_cmd_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .full  (q_full),
    .empty (q_empty)
  );

  sle_back #(.LINE_CAPACITY(LINE_CAPACITY)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_cmd         (q_dout),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_kind      (out_kind),
    .out_data_byte (out_data_byte),
    .out_last      (out_last)
  );

endmodule

// ----- hw/rtl/sle_checker.sv -----
// Port-level checks for the serial line editor, bound to the top level.
// Depends on sle_pkg for result kind codes.
module sle_checker import sle_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic [7:0] out_data_byte,
  input logic       out_last
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // End marker closes the transaction and carries zero data
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_END |-> out_last && out_data_byte == 8'h00)
    else $error("end marker malformed");

  // Line bytes are never the final result of a transaction
  a_line_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_LINE |-> !out_last)
    else $error("line byte flagged last");

  // Only the three defined kinds appear
  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_kind == KIND_ECHO || out_kind == KIND_LINE || out_kind == KIND_END)
    else $error("illegal result kind");

  // A taken CR echo is directly followed by no other echo: only line data or the end marker
  a_line_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_kind == KIND_ECHO && out_data_byte == CH_CR && !out_last
    |=> !out_valid || out_kind == KIND_LINE || out_kind == KIND_END)
    else $error("CR echo not followed by line data or end marker");

endmodule

bind serial_line_editor_top sle_checker u_sle_checker (.*);
